FILE: rtl/paged_fixed_block_allocator_unit_assert.svh
// Assertion macros used by the allocator RTL.
`ifndef PAGED_FIXED_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define PAGED_FIXED_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// The expression holds at every clock edge outside reset.
`define PFBA_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("allocator check failed");

// The consequent holds in the cycle of the antecedent.
`define PFBA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// The consequent holds in the cycle after the antecedent.
`define PFBA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

FILE: rtl/pfba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pfba_pkg;
    localparam int MAX_PAGES  = 16;
    localparam int MAX_SLOTS  = 64;
    localparam int PAGE_W     = $clog2(MAX_PAGES);
    localparam int SLOT_W     = $clog2(MAX_SLOTS);
    localparam int PREF_W     = PAGE_W + 1;
    localparam int SREF_W     = SLOT_W + 1;
    localparam int ADDR_W     = PAGE_W + SLOT_W;
    localparam int CNT_W      = $clog2(MAX_PAGES + 1);
    localparam int TOTAL_W    = $clog2(MAX_PAGES * MAX_SLOTS + 1);
    localparam int CFG_W      = 7;

    localparam logic [PREF_W-1:0] NO_PAGE = PREF_W'(MAX_PAGES);
    localparam logic [SREF_W-1:0] NO_SLOT = SREF_W'(MAX_SLOTS);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FRAME = 2'd1,
        ST_BAD_FREE = 2'd2
    } t_status;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_POP,
        S_OPEN,
        S_FILL,
        S_FREE,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

FILE: rtl/pfba_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module pfba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/paged_fixed_block_allocator_unit.sv
// Fixed-block pool allocator over 16 page frames of up to 64 slots. Each
// request is one transfer on the input channel and gives one result transfer.
// A free passes through the free state and then the done state. An allocate
// from a page with room reads the head frame and pops a slot, after any full
// pages at the head of the list have been unlinked. Opening a new page writes
// its slot chain into the slot link memory one entry per cycle through its
// single write port. An allocate that finds no idle frame goes from the open
// state straight to the done state. A finished result waits in the output
// register while the next request is taken, in the cycle after the result
// enters it. blocks_per_page is sampled when a page is opened.
`timescale 1ns / 1ps
`default_nettype none
`include "paged_fixed_block_allocator_unit_assert.svh"
module paged_fixed_block_allocator_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [pfba_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_command,
    input  wire logic [pfba_pkg::PAGE_W-1:0]   i_page_index,
    input  wire logic [pfba_pkg::SLOT_W-1:0]   i_slot_index,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [1:0]                         o_status,
    output logic [pfba_pkg::PAGE_W-1:0]        o_granted_page,
    output logic [pfba_pkg::SLOT_W-1:0]        o_granted_slot,
    output logic [pfba_pkg::CNT_W-1:0]         o_pages_in_use,
    output logic [pfba_pkg::TOTAL_W-1:0]       o_blocks_total
);
    import pfba_pkg::*;

    t_state r_state, n_state;

    logic [CFG_W-1:0]  r_cfg;
    logic [SREF_W-1:0] eff_size;

    logic              r_active [MAX_PAGES];
    logic              r_listed [MAX_PAGES];
    logic [SREF_W-1:0] r_free   [MAX_PAGES];
    logic [SREF_W-1:0] r_fhead  [MAX_PAGES];
    logic [SREF_W-1:0] r_size   [MAX_PAGES];
    logic [PREF_W-1:0] r_next   [MAX_PAGES];
    logic [PREF_W-1:0] r_prev   [MAX_PAGES];
    logic [PREF_W-1:0] r_head;
    logic [CNT_W-1:0]  r_open_pages;
    logic [TOTAL_W-1:0] r_open_blocks;

    logic [PAGE_W-1:0] r_page;
    logic [SLOT_W-1:0] r_slot;
    logic [PAGE_W-1:0] r_pop_page;
    logic [PAGE_W-1:0] r_fill_page;
    logic [SREF_W-1:0] r_fill_n;
    logic [SLOT_W-1:0] r_fill_i;

    t_status           r_res_status;
    logic [PAGE_W-1:0] r_res_page;
    logic [SLOT_W-1:0] r_res_slot;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [SREF_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [SREF_W-1:0] ram_rdata;

    logic              in_xfer;
    logic              out_free;
    logic [PAGE_W-1:0] head_pg;
    logic              head_ok;
    logic              idle_found;
    logic [PAGE_W-1:0] idle_pg;
    logic [PAGE_W-1:0] unl_pg;
    logic [PREF_W-1:0] unl_pr;
    logic [PREF_W-1:0] unl_nx;
    logic              free_bad;
    logic [SREF_W:0]   free_inc;
    logic              free_close;
    logic              fill_last;
    logic [SREF_W-1:0] fill_link;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != S_IDLE);
    assign in_xfer     = i_valid && !o_stall;
    assign out_free    = !o_valid || !i_stall;

    assign eff_size = (r_cfg == '0) ? SREF_W'(1)
                    : (r_cfg > CFG_W'(MAX_SLOTS)) ? NO_SLOT : SREF_W'(r_cfg);

    assign head_pg = r_head[PAGE_W-1:0];
    assign head_ok = (r_free[head_pg] != '0) && (r_fhead[head_pg] < r_size[head_pg]);

    always_comb begin
        idle_found = 1'b0;
        idle_pg    = '0;
        for (int k = MAX_PAGES - 1; k >= 0; k--) begin
            if (!r_active[k]) begin
                idle_found = 1'b1;
                idle_pg    = PAGE_W'(k);
            end
        end
    end

    // The frame to unlink is the head frame on allocate, the freed frame on free.
    assign unl_pg = (r_state == S_FREE) ? r_page : head_pg;
    assign unl_pr = r_prev[unl_pg];
    assign unl_nx = r_next[unl_pg];

    assign free_bad   = !r_active[r_page] || (SREF_W'(r_slot) >= r_size[r_page]);
    assign free_inc   = {1'b0, r_free[r_page]} + 1'b1;
    assign free_close = (free_inc >= {1'b0, r_size[r_page]});

    assign fill_last = ({1'b0, r_fill_i} + 1'b1 == r_fill_n);
    assign fill_link = fill_last ? NO_SLOT : SREF_W'({1'b0, r_fill_i} + 1'b1);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {r_page, r_slot};
        ram_wdata = r_fhead[r_page];
        if (r_state == S_FILL) begin
            ram_we    = 1'b1;
            ram_waddr = {r_fill_page, r_fill_i};
            ram_wdata = fill_link;
        end else if (r_state == S_FREE && !free_bad) begin
            ram_we = 1'b1;
        end
    end
    assign ram_raddr = {head_pg, r_fhead[head_pg][SLOT_W-1:0]};

    pfba_ram #(
        .WIDTH (SREF_W),
        .DEPTH (MAX_PAGES * MAX_SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = (t_cmd'(i_command) == CMD_FREE) ? S_FREE : S_HEAD;
                end
            end
            S_HEAD: begin
                if (r_head == NO_PAGE) begin
                    n_state = S_OPEN;
                end else if (head_ok) begin
                    n_state = S_POP;
                end
            end
            S_POP:  n_state = S_DONE;
            S_OPEN: n_state = idle_found ? S_FILL : S_DONE;
            S_FILL: n_state = fill_last ? S_DONE : S_FILL;
            S_FREE: n_state = S_DONE;
            S_DONE: n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg         <= CFG_W'(MAX_SLOTS);
            r_head        <= NO_PAGE;
            r_open_pages  <= '0;
            r_open_blocks <= '0;
            o_valid       <= 1'b0;
            for (int k = 0; k < MAX_PAGES; k++) begin
                r_active[k] <= 1'b0;
                r_listed[k] <= 1'b0;
                r_free[k]   <= '0;
                r_fhead[k]  <= NO_SLOT;
                r_size[k]   <= '0;
                r_next[k]   <= NO_PAGE;
                r_prev[k]   <= NO_PAGE;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
            if (o_valid && !i_stall && r_state != S_DONE) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_page       <= i_page_index;
                        r_slot       <= i_slot_index;
                        r_res_status <= ST_OK;
                        r_res_page   <= '0;
                        r_res_slot   <= '0;
                    end
                end
                S_HEAD: begin
                    if (r_head != NO_PAGE) begin
                        if (head_ok) begin
                            r_pop_page <= head_pg;
                        end else begin
                            if (!unl_pr[PAGE_W]) r_next[unl_pr[PAGE_W-1:0]] <= unl_nx;
                            if (!unl_nx[PAGE_W]) r_prev[unl_nx[PAGE_W-1:0]] <= unl_pr;
                            r_head           <= unl_nx;
                            r_next[unl_pg]   <= NO_PAGE;
                            r_prev[unl_pg]   <= NO_PAGE;
                            r_listed[unl_pg] <= 1'b0;
                        end
                    end
                end
                S_POP: begin
                    r_fhead[r_pop_page] <= ram_rdata;
                    r_free[r_pop_page]  <= r_free[r_pop_page] - 1'b1;
                    r_res_page          <= r_pop_page;
                    r_res_slot          <= r_fhead[r_pop_page][SLOT_W-1:0];
                end
                S_OPEN: begin
                    if (idle_found) begin
                        r_fill_page <= idle_pg;
                        r_fill_n    <= eff_size;
                        r_fill_i    <= '0;
                    end else begin
                        r_res_status <= ST_NO_FRAME;
                    end
                end
                S_FILL: begin
                    r_fill_i <= r_fill_i + 1'b1;
                    if (fill_last) begin
                        // Open the frame with slot 0 already handed out.
                        r_active[r_fill_page] <= 1'b1;
                        r_listed[r_fill_page] <= 1'b1;
                        r_size[r_fill_page]   <= r_fill_n;
                        r_free[r_fill_page]   <= r_fill_n - 1'b1;
                        r_fhead[r_fill_page]  <= (r_fill_n > SREF_W'(1)) ? SREF_W'(1) : NO_SLOT;
                        r_prev[r_fill_page]   <= NO_PAGE;
                        r_next[r_fill_page]   <= r_head;
                        if (!r_head[PAGE_W]) r_prev[head_pg] <= {1'b0, r_fill_page};
                        r_head        <= {1'b0, r_fill_page};
                        r_open_pages  <= r_open_pages + 1'b1;
                        r_open_blocks <= r_open_blocks + TOTAL_W'(r_fill_n);
                        r_res_page    <= r_fill_page;
                        r_res_slot    <= '0;
                    end
                end
                S_FREE: begin
                    if (free_bad) begin
                        r_res_status <= ST_BAD_FREE;
                    end else if (free_close) begin
                        if (r_listed[r_page] || (r_head == {1'b0, r_page})) begin
                            if (!unl_pr[PAGE_W]) r_next[unl_pr[PAGE_W-1:0]] <= unl_nx;
                            if (!unl_nx[PAGE_W]) r_prev[unl_nx[PAGE_W-1:0]] <= unl_pr;
                            if (r_head == {1'b0, r_page}) r_head <= unl_nx;
                            r_next[r_page]   <= NO_PAGE;
                            r_prev[r_page]   <= NO_PAGE;
                            r_listed[r_page] <= 1'b0;
                        end
                        r_active[r_page] <= 1'b0;
                        r_open_pages     <= r_open_pages - 1'b1;
                        r_open_blocks    <= r_open_blocks - TOTAL_W'(r_size[r_page]);
                        r_size[r_page]   <= '0;
                        r_free[r_page]   <= '0;
                        r_fhead[r_page]  <= NO_SLOT;
                    end else begin
                        r_fhead[r_page] <= SREF_W'(r_slot);
                        r_free[r_page]  <= free_inc[SREF_W-1:0];
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        o_valid        <= 1'b1;
                        o_status       <= r_res_status;
                        o_granted_page <= r_res_page;
                        o_granted_slot <= r_res_slot;
                        o_pages_in_use <= r_open_pages;
                        o_blocks_total <= r_open_blocks;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    `PFBA_ASSERT_ALWAYS(a_pages_bound, r_open_pages <= CNT_W'(MAX_PAGES))
    `PFBA_ASSERT_IMPL(a_pop_after_head, r_state == S_POP, $past(r_state) == S_HEAD)
    `PFBA_ASSERT_NEXT(a_free_cmd, r_state == S_IDLE && in_xfer && i_command, r_state == S_FREE)
    `PFBA_ASSERT_IMPL(a_status_code, o_valid, o_status != 2'd3)
endmodule
`default_nettype wire

FILE: verif/tb_paged_fixed_block_allocator_unit.sv
`timescale 1ns / 1ps
module tb_paged_fixed_block_allocator_unit;
    import pfba_pkg::*;

    typedef struct packed {
        logic [1:0]         status;
        logic [PAGE_W-1:0]  gpage;
        logic [SLOT_W-1:0]  gslot;
        logic [CNT_W-1:0]   pages;
        logic [TOTAL_W-1:0] blocks;
    } t_grant;

    // One directed row: a request plus an optional typed-in result.
    typedef struct {
        t_cmd              cmd;
        logic [PAGE_W-1:0] page;
        logic [SLOT_W-1:0] slot;
        bit                has_exp;
        t_grant            exp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic i_command = 1'b0;
    logic [PAGE_W-1:0] i_page_index = '0;
    logic [SLOT_W-1:0] i_slot_index = '0;
    logic i_stall = 1'b0;
    wire o_cfg_ready, o_stall, o_valid;
    wire [1:0] o_status;
    wire [PAGE_W-1:0] o_granted_page;
    wire [SLOT_W-1:0] o_granted_slot;
    wire [CNT_W-1:0] o_pages_in_use;
    wire [TOTAL_W-1:0] o_blocks_total;

    paged_fixed_block_allocator_unit uut (.*);

    always #6 i_clk = ~i_clk;

    // Shadow copy of the allocator state.
    int pool_cfg;
    bit fr_active[MAX_PAGES];
    bit fr_listed[MAX_PAGES];
    int fr_free[MAX_PAGES];
    int fr_head[MAX_PAGES];
    int fr_size[MAX_PAGES];
    int link_mem[MAX_PAGES*MAX_SLOTS];
    int nxt[MAX_PAGES];
    int prv[MAX_PAGES];
    int lhead;
    int n_pages;
    int n_blocks;

    t_grant pending_grants[$];
    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    function automatic void pool_reset();
        pool_cfg = 64;
        for (int i = 0; i < MAX_PAGES; i++) begin
            fr_active[i] = 0; fr_listed[i] = 0; fr_free[i] = 0;
            fr_head[i] = MAX_SLOTS; fr_size[i] = 0;
            nxt[i] = MAX_PAGES; prv[i] = MAX_PAGES;
        end
        foreach (link_mem[i]) link_mem[i] = 0;
        lhead = MAX_PAGES; n_pages = 0; n_blocks = 0;
    endfunction

    function automatic void drop_frame(int p);
        if (prv[p] < MAX_PAGES) nxt[prv[p]] = nxt[p];
        if (nxt[p] < MAX_PAGES) prv[nxt[p]] = prv[p];
        if (lhead == p) lhead = nxt[p];
        nxt[p] = MAX_PAGES; prv[p] = MAX_PAGES; fr_listed[p] = 0;
    endfunction

    function automatic int take_slot(int p);
        int s;
        s = fr_head[p];
        fr_head[p] = link_mem[p*MAX_SLOTS + s];
        fr_free[p]--;
        return s;
    endfunction

    function automatic t_grant serve_request(t_cmd cmd, int p, int s);
        t_grant r;
        bit done;
        int f, n, h;
        r = '0; done = 0; f = MAX_PAGES;
        if (cmd == CMD_ALLOC) begin
            for (int i = 0; i <= MAX_PAGES && !done; i++) begin
                h = lhead;
                if (h >= MAX_PAGES) break;
                if (fr_free[h] != 0 && fr_head[h] < fr_size[h]) begin
                    r.gpage = PAGE_W'(h); r.gslot = SLOT_W'(take_slot(h)); done = 1;
                end else begin
                    drop_frame(h);
                end
            end
            if (!done) begin
                for (int i = 0; i < MAX_PAGES; i++)
                    if (!fr_active[i]) begin f = i; break; end
                if (f >= MAX_PAGES) begin
                    r.status = ST_NO_FRAME;
                end else begin
                    n = pool_cfg == 0 ? 1 : (pool_cfg > MAX_SLOTS ? MAX_SLOTS : pool_cfg);
                    for (int i = 0; i < n; i++)
                        link_mem[f*MAX_SLOTS + i] = (i + 1 < n) ? i + 1 : MAX_SLOTS;
                    fr_active[f] = 1; fr_size[f] = n; fr_free[f] = n; fr_head[f] = 0;
                    prv[f] = MAX_PAGES; nxt[f] = lhead;
                    if (lhead < MAX_PAGES) prv[lhead] = f;
                    lhead = f; fr_listed[f] = 1;
                    n_pages++; n_blocks += n;
                    r.gpage = PAGE_W'(f); r.gslot = SLOT_W'(take_slot(f));
                end
            end
        end else if (!fr_active[p] || s >= fr_size[p]) begin
            r.status = ST_BAD_FREE;
        end else begin
            link_mem[p*MAX_SLOTS + s] = fr_head[p];
            fr_head[p] = s;
            fr_free[p]++;
            if (fr_free[p] >= fr_size[p]) begin
                if (fr_listed[p] || lhead == p) drop_frame(p);
                fr_active[p] = 0; n_pages--; n_blocks -= fr_size[p];
                fr_size[p] = 0; fr_free[p] = 0; fr_head[p] = MAX_SLOTS;
            end
        end
        r.pages = CNT_W'(n_pages);
        r.blocks = TOTAL_W'(n_blocks);
        return r;
    endfunction

    // Random output stall; results are checked at the transfer edge.
    always @(posedge i_clk) begin
        t_grant got, want;
        i_stall <= ($urandom_range(99) < stall_pct);
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_status, o_granted_page, o_granted_slot, o_pages_in_use, o_blocks_total};
            if (pending_grants.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = pending_grants.pop_front();
                n_checked++;
                if (got !== want) begin
                    $display("%0t: mismatch expected st=%0d pg=%0d sl=%0d pages=%0d blk=%0d",
                             $time, want.status, want.gpage, want.gslot, want.pages,
                             want.blocks);
                    $display("%0t:          actual   st=%0d pg=%0d sl=%0d pages=%0d blk=%0d",
                             $time, got.status, got.gpage, got.gslot, got.pages, got.blocks);
                    errors++;
                end
            end
        end
    end

    task automatic set_pool_size(int v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v[CFG_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        pool_cfg = v;
    endtask

    // Holds one transfer on the input channel; the typed-in result, if any,
    // must agree with the shadow state.
    task automatic send_request(t_cmd cmd, int p, int s, bit has_exp = 0,
                                t_grant exp = '0);
        t_grant r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_page_index <= p[PAGE_W-1:0];
        i_slot_index <= s[SLOT_W-1:0];
        do @(posedge i_clk); while (o_stall);
        r = serve_request(cmd, p, s);
        if (has_exp && r !== exp) begin
            $display("%0t: directed row expected %h, shadow gives %h", $time, exp, r);
            errors++;
        end
        pending_grants.push_back(r);
        n_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
        // Every result has left by now; the wait that follows only separates phases.
        repeat (80) @(posedge i_clk);
    endtask

    function automatic t_grant mk(int st, int pg, int sl, int pages, int blk);
        t_grant r;
        r.status = 2'(st); r.gpage = PAGE_W'(pg); r.gslot = SLOT_W'(sl);
        r.pages = CNT_W'(pages); r.blocks = TOTAL_W'(blk);
        return r;
    endfunction

    task automatic random_phase(int n_items, int size_v);
        int busy[$];
        int k, p, s;
        set_pool_size(size_v);
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(9) == 0) begin
                send_request(CMD_FREE, $urandom_range(15), $urandom_range(63));
            end else if ($urandom_range(1) == 0 || busy.size() == 0) begin
                send_request(CMD_ALLOC, $urandom_range(15), $urandom_range(63));
                if (pending_grants[$].status == ST_OK)
                    busy.push_back(pending_grants[$].gpage * 64 + pending_grants[$].gslot);
            end else begin
                k = $urandom_range(busy.size() - 1);
                p = busy[k] / 64; s = busy[k] % 64;
                busy.delete(k);
                send_request(CMD_FREE, p, s);
            end
            if (i == n_items / 2) begin
                // Hold off until every result is back.
                i_valid <= 1'b0;
                while (pending_grants.size() != 0) @(posedge i_clk);
            end
        end
        // Release everything, so that the next size starts from empty pages.
        while (busy.size() != 0) begin
            send_request(CMD_FREE, busy[0] / 64, busy[0] % 64);
            void'(busy.pop_front());
        end
        drain();
    endtask

    initial begin
        t_row rows[$];
        t_row rw;
        pool_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Pool size 2, two frames in play.
        set_pool_size(2);
        rw = '{CMD_FREE, 0, 0, 1, mk(ST_BAD_FREE, 0, 0, 0, 0)};      rows.push_back(rw);
        rw = '{CMD_ALLOC, 15, 63, 1, mk(ST_OK, 0, 0, 1, 2)};         rows.push_back(rw);
        rw = '{CMD_ALLOC, 0, 0, 1, mk(ST_OK, 0, 1, 1, 2)};           rows.push_back(rw);
        rw = '{CMD_ALLOC, 0, 0, 1, mk(ST_OK, 1, 0, 2, 4)};           rows.push_back(rw);
        rw = '{CMD_FREE, 0, 2, 1, mk(ST_BAD_FREE, 0, 0, 2, 4)};      rows.push_back(rw);
        rw = '{CMD_FREE, 15, 63, 1, mk(ST_BAD_FREE, 0, 0, 2, 4)};    rows.push_back(rw);
        rw = '{CMD_FREE, 0, 1, 0, '0};                               rows.push_back(rw);
        rw = '{CMD_FREE, 0, 1, 0, '0};                               rows.push_back(rw);
        rw = '{CMD_ALLOC, 0, 0, 0, '0};                              rows.push_back(rw);
        rw = '{CMD_FREE, 1, 0, 0, '0};                               rows.push_back(rw);
        rw = '{CMD_FREE, 1, 1, 0, '0};                               rows.push_back(rw);
        foreach (rows[i]) send_request(rows[i].cmd, rows[i].page, rows[i].slot,
                                       rows[i].has_exp, rows[i].exp);
        drain();

        // Size 0 acts as one slot: sixteen allocations fill every frame.
        set_pool_size(0);
        for (int i = 0; i < 16; i++) send_request(CMD_ALLOC, 0, 0);
        send_request(CMD_ALLOC, 0, 0, 1, mk(ST_NO_FRAME, 0, 0, 16, 16));
        for (int i = 0; i < 16; i++) send_request(CMD_FREE, i, 0);
        drain();

        // Size above the limit acts as 64 slots.
        set_pool_size(127);
        send_request(CMD_ALLOC, 0, 0, 1, mk(ST_OK, 0, 0, 1, 64));
        send_request(CMD_FREE, 0, 63);
        send_request(CMD_FREE, 0, 0);
        drain();

        send_idle_pct = 0;  stall_pct = 0;  random_phase(160, 3);
        send_idle_pct = 88; stall_pct = 0;  random_phase(140, 1);
        send_idle_pct = 0;  stall_pct = 88; random_phase(140, 5);
        send_idle_pct = 16; stall_pct = 16; random_phase(200, 8);
        send_idle_pct = 0;  stall_pct = 0;  random_phase(90, 64);
        send_idle_pct = 16; stall_pct = 16; random_phase(90, 4);

        $display("Ran %0d requests, %0d results checked, page sizes 1 to 64,", n_sent,
                 n_checked);
        $display("with bad frees, exhausted frames and idle or stall phases.");
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
